@@ rtl/cbs_pkg.sv @@
`timescale 1ns / 1ps

package cbs_pkg;

	localparam int DIV_STEPS = 32;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
	localparam logic [15:0] RIGHT_ANGLE = 16'd16384;
	localparam logic [63:0] INV_PI_Q32 = 64'h0000_0000_517C_C1B7;

	typedef enum logic [2:0] {
		BR_INSCRIBED,
		BR_APEX,
		BR_ERROR,
		BR_SPH_WIDE,
		BR_SPH_NARROW,
		BR_FLAT_WIDE,
		BR_FLAT_NARROW
	} branch_t;

	typedef struct packed {
		logic signed [31:0] apex_x;
		logic signed [31:0] apex_y;
		logic signed [31:0] apex_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic [30:0] depth;
		logic inscribed;
		logic spherical;
		logic big;
	} ctx_t;

	typedef struct packed {
		branch_t br;
		logic [30:0] s;
		logic [30:0] c;
		logic [30:0] rad_sw;
		logic [30:0] dist_sw;
		logic ovf;
		logic [31:0] q;
	} side_t;

	typedef struct packed {
		logic signed [31:0] sphere_x;
		logic signed [31:0] sphere_y;
		logic signed [31:0] sphere_z;
		logic [30:0] sphere_radius;
		logic angle_error;
		logic saturated;
	} res_t;

	// Restoring division, evaluated only while the design is elaborated.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Rotation angle of one CORDIC stage in units of pi/2^30.
	function automatic logic [31:0] stage_angle(input int unsigned i);
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] prod;
		int unsigned k;
		acc = '0;
		k = 0;
		if (i == 0) begin
			return 32'h1000_0000;
		end
		while ((2 * k + 1) * i <= 60) begin
			t = udiv64(64'd1 << (60 - (2 * k + 1) * i), 64'(2 * k + 1));
			if (k[0]) begin
				acc = acc - t;
			end else begin
				acc = acc + t;
			end
			k++;
		end
		prod = (acc >> 28) * INV_PI_Q32 + (64'd1 << 33);
		return 32'(prod >> 34);
	endfunction

endpackage

@@ rtl/cbs_cone_if.sv @@
`timescale 1ns / 1ps

interface cbs_cone_if;
	logic valid;
	logic ready;
	logic signed [31:0] apex_x;
	logic signed [31:0] apex_y;
	logic signed [31:0] apex_z;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic [15:0] half_angle;
	logic [30:0] cone_depth;
	logic spherical_cap;
	logic inscribed_mode;

	modport source (
		output valid, apex_x, apex_y, apex_z, axis_x, axis_y, axis_z,
		output half_angle, cone_depth, spherical_cap, inscribed_mode,
		input ready
	);
	modport sink (
		input valid, apex_x, apex_y, apex_z, axis_x, axis_y, axis_z,
		input half_angle, cone_depth, spherical_cap, inscribed_mode,
		output ready
	);
endinterface

@@ rtl/cbs_sphere_if.sv @@
`timescale 1ns / 1ps

interface cbs_sphere_if;
	logic valid;
	logic ready;
	logic signed [31:0] sphere_x;
	logic signed [31:0] sphere_y;
	logic signed [31:0] sphere_z;
	logic [30:0] sphere_radius;
	logic angle_error;
	logic saturated;

	modport source (
		output valid, sphere_x, sphere_y, sphere_z, sphere_radius, angle_error, saturated,
		input ready
	);
	modport sink (
		input valid, sphere_x, sphere_y, sphere_z, sphere_radius, angle_error, saturated,
		output ready
	);
endinterface

@@ rtl/cone_bounding_sphere_top.sv @@
`timescale 1ns / 1ps
// Cone to sphere converter.
// The cone channel takes one cone per beat: apex, unit axis, half-angle, depth, end
// shape and mode. The sphere channel gives one sphere per beat: center, radius, an
// angle error flag and a saturation flag. Every cone yields exactly one sphere, in order.
// An accepted cone passes through every stage below and then the output register.
// The pipeline runs a CORDIC with one stage per iteration, a restoring divider with
// one quotient bit per stage, and registered multiply and saturate stages, so a new
// cone is taken in every cycle while cone.ready is high.
// A one-entry skid register sits behind the pipeline. When the receiver stalls, the
// result goes to the output register, the next one to the skid register, and then
// the whole pipeline holds with cone.ready low until the receiver takes a beat.
// Reset clears all valid bits, including those of the skid and output registers; no
// result is presented after reset until a cone has passed through.
module cone_bounding_sphere_top
	import cbs_pkg::*;
#(
	parameter int TRIG_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	cbs_cone_if.sink cone,
	cbs_sphere_if.source sphere
);

	function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
		if (v < 0) begin
			return '0;
		end
		if (v > 34'sh0_4000_0000) begin
			return ONE_Q30;
		end
		return v[30:0];
	endfunction

	function automatic logic [32:0] coord_sat(input logic signed [31:0] apex,
		input logic signed [33:0] off);
		logic signed [34:0] sum;
		sum = 35'(apex) + 35'(off);
		if (sum > 35'sd2147483647) begin
			return {1'b1, 32'h7FFF_FFFF};
		end
		if (sum < -35'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, sum[31:0]};
	endfunction

	logic en;
	logic push;
	logic o_take;
	logic o_v_q;
	logic skid_v_q;
	res_t o_q;
	res_t skid_q;

	assign en = !skid_v_q;
	assign cone.ready = en;

	// Stage 1: capture and angle clamp.
	ctx_t ctx_in;
	logic [15:0] angle_c;
	logic [31:0] z_in;
	ctx_t ctx_s1;
	logic signed [31:0] z_s1;
	logic v_s1;

	always_comb begin
		ctx_in.apex_x = cone.apex_x;
		ctx_in.apex_y = cone.apex_y;
		ctx_in.apex_z = cone.apex_z;
		ctx_in.axis_x = cone.axis_x;
		ctx_in.axis_y = cone.axis_y;
		ctx_in.axis_z = cone.axis_z;
		ctx_in.depth = cone.cone_depth;
		ctx_in.inscribed = cone.inscribed_mode;
		ctx_in.spherical = cone.spherical_cap;
		ctx_in.big = cone.half_angle >= RIGHT_ANGLE;
		priority if (cone.inscribed_mode) begin
			angle_c = (cone.half_angle > RIGHT_ANGLE) ? RIGHT_ANGLE : cone.half_angle;
		end else if (cone.half_angle >= RIGHT_ANGLE) begin
			angle_c = '0;
		end else begin
			angle_c = cone.half_angle;
		end
		z_in = {2'b00, angle_c[14:0], 15'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cone.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			z_s1 <= $signed(z_in);
		end
	end

	// Stage 2: CORDIC, one rotation per register stage.
	logic signed [33:0] cx_s2 [TRIG_STAGES];
	logic signed [33:0] cy_s2 [TRIG_STAGES];
	logic signed [31:0] cz_s2 [TRIG_STAGES];
	ctx_t cc_s2 [TRIG_STAGES];
	logic cv_s2 [TRIG_STAGES];

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
		localparam logic signed [31:0] ANG = $signed(stage_angle(i));
		logic signed [33:0] xi;
		logic signed [33:0] yi;
		logic signed [31:0] zi;
		ctx_t ci;
		logic vi;
		if (i == 0) begin : g_first
			assign xi = $signed(34'(CORDIC_GAIN));
			assign yi = '0;
			assign zi = z_s1;
			assign ci = ctx_s1;
			assign vi = v_s1;
		end else begin : g_next
			assign xi = cx_s2[i-1];
			assign yi = cy_s2[i-1];
			assign zi = cz_s2[i-1];
			assign ci = cc_s2[i-1];
			assign vi = cv_s2[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s2[i] <= 1'b0;
			end else if (en) begin
				cv_s2[i] <= vi;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[31]) begin
					cx_s2[i] <= xi - (yi >>> i);
					cy_s2[i] <= yi + (xi >>> i);
					cz_s2[i] <= zi - ANG;
				end else begin
					cx_s2[i] <= xi + (yi >>> i);
					cy_s2[i] <= yi - (xi >>> i);
					cz_s2[i] <= zi + ANG;
				end
				cc_s2[i] <= ci;
			end
		end
	end

	// Stage 3: clamp sine and cosine, pick the branch.
	logic [30:0] sin_c;
	logic [30:0] cos_c;
	branch_t br_c;
	ctx_t ctx_s3;
	branch_t br_s3;
	logic [30:0] s_s3;
	logic [30:0] c_s3;
	logic v_s3;

	always_comb begin
		sin_c = clamp_q30(cy_s2[TRIG_STAGES-1]);
		cos_c = clamp_q30(cx_s2[TRIG_STAGES-1]);
		priority if (cc_s2[TRIG_STAGES-1].inscribed) begin
			br_c = BR_INSCRIBED;
		end else if (cc_s2[TRIG_STAGES-1].big) begin
			br_c = cc_s2[TRIG_STAGES-1].spherical ? BR_APEX : BR_ERROR;
		end else if (cc_s2[TRIG_STAGES-1].spherical) begin
			br_c = (sin_c >= cos_c) ? BR_SPH_WIDE : BR_SPH_NARROW;
		end else begin
			br_c = (sin_c > cos_c) ? BR_FLAT_WIDE : BR_FLAT_NARROW;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= cc_s2[TRIG_STAGES-1];
			br_s3 <= br_c;
			s_s3 <= sin_c;
			c_s3 <= cos_c;
		end
	end

	// Stage 4: depth times sine and cosine.
	ctx_t ctx_s4;
	branch_t br_s4;
	logic [30:0] s_s4;
	logic [30:0] c_s4;
	logic [61:0] ms_s4;
	logic [61:0] mc_s4;
	logic v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_s3;
			br_s4 <= br_s3;
			s_s4 <= s_s3;
			c_s4 <= c_s3;
			ms_s4 <= 62'(ctx_s3.depth) * 62'(s_s3);
			mc_s4 <= 62'(ctx_s3.depth) * 62'(c_s3);
		end
	end

	// Stage 5: dividend and divisor with the rounding half added, overflow check.
	logic [63:0] num5;
	logic [31:0] den5;
	logic [63:0] np5;
	logic [61:0] rsw5;
	logic [61:0] dsw5;
	ctx_t ctx_s5;
	side_t side_s5;
	logic [31:0] rem_s5;
	logic [31:0] low_s5;
	logic [31:0] den_s5;
	logic v_s5;

	always_comb begin
		num5 = '0;
		den5 = 32'd1;
		unique case (br_s4)
			BR_INSCRIBED: begin
				num5 = {3'b0, ctx_s4.depth, 30'b0};
				den5 = {1'b0, ONE_Q30} + {1'b0, s_s4};
			end
			BR_SPH_NARROW: begin
				num5 = {4'b0, ctx_s4.depth, 29'b0};
				den5 = {1'b0, c_s4};
			end
			BR_FLAT_WIDE: begin
				num5 = {2'b0, ms_s4};
				den5 = {1'b0, c_s4};
			end
			BR_FLAT_NARROW: begin
				num5 = {3'b0, s_s4, 30'b0};
				den5 = {1'b0, c_s4};
			end
			default: begin
			end
		endcase
		np5 = num5 + {33'b0, den5[31:1]};
		rsw5 = ms_s4 + 62'h2000_0000;
		dsw5 = mc_s4 + 62'h2000_0000;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5 <= ctx_s4;
			side_s5.br <= br_s4;
			side_s5.s <= s_s4;
			side_s5.c <= c_s4;
			side_s5.rad_sw <= rsw5[60:30];
			side_s5.dist_sw <= dsw5[60:30];
			side_s5.ovf <= np5[63:32] >= den5;
			side_s5.q <= '0;
			rem_s5 <= np5[63:32];
			low_s5 <= np5[31:0];
			den_s5 <= den5;
		end
	end

	// Stage 6: restoring divider, one quotient bit per register stage.
	logic [31:0] dr_s6 [DIV_STEPS];
	logic [31:0] dl_s6 [DIV_STEPS];
	logic [31:0] dq_s6 [DIV_STEPS];
	logic [31:0] dd_s6 [DIV_STEPS];
	ctx_t dc_s6 [DIV_STEPS];
	side_t ds_s6 [DIV_STEPS];
	logic dv_s6 [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [31:0] ri;
		logic [31:0] li;
		logic [31:0] qi;
		logic [31:0] di;
		ctx_t ci;
		side_t si;
		logic vi;
		logic [32:0] trial;
		logic [32:0] diff;
		if (k == 0) begin : g_first
			assign ri = rem_s5;
			assign li = low_s5;
			assign qi = '0;
			assign di = den_s5;
			assign ci = ctx_s5;
			assign si = side_s5;
			assign vi = v_s5;
		end else begin : g_next
			assign ri = dr_s6[k-1];
			assign li = dl_s6[k-1];
			assign qi = dq_s6[k-1];
			assign di = dd_s6[k-1];
			assign ci = dc_s6[k-1];
			assign si = ds_s6[k-1];
			assign vi = dv_s6[k-1];
		end
		assign trial = {ri, li[31]};
		assign diff = trial - {1'b0, di};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s6[k] <= 1'b0;
			end else if (en) begin
				dv_s6[k] <= vi;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, di}) begin
					dr_s6[k] <= diff[31:0];
					dq_s6[k] <= {qi[30:0], 1'b1};
				end else begin
					dr_s6[k] <= trial[31:0];
					dq_s6[k] <= {qi[30:0], 1'b0};
				end
				dl_s6[k] <= {li[30:0], 1'b0};
				dd_s6[k] <= di;
				dc_s6[k] <= ci;
				ds_s6[k] <= si;
			end
		end
	end

	// Stage 7: p times sine or tangent squared.
	logic [31:0] q7;
	logic [30:0] t7;
	logic [30:0] ma7;
	logic [30:0] mb7;
	side_t side7;
	ctx_t ctx_s7;
	side_t side_s7;
	logic [61:0] prod_s7;
	logic v_s7;

	always_comb begin
		q7 = dq_s6[DIV_STEPS-1];
		if (ds_s6[DIV_STEPS-1].c == '0 || ds_s6[DIV_STEPS-1].ovf || q7 > {1'b0, ONE_Q30}) begin
			t7 = ONE_Q30;
		end else begin
			t7 = q7[30:0];
		end
		if (ds_s6[DIV_STEPS-1].br == BR_INSCRIBED) begin
			ma7 = q7[30:0];
			mb7 = ds_s6[DIV_STEPS-1].s;
		end else begin
			ma7 = t7;
			mb7 = t7;
		end
		side7 = ds_s6[DIV_STEPS-1];
		side7.q = q7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s7 <= dc_s6[DIV_STEPS-1];
			side_s7 <= side7;
			prod_s7 <= 62'(ma7) * 62'(mb7);
		end
	end

	// Stage 8: round the product to Q30.
	logic [62:0] r2sum8;
	ctx_t ctx_s8;
	side_t side_s8;
	logic [31:0] r2_s8;
	logic v_s8;

	assign r2sum8 = {1'b0, prod_s7} + 63'h2000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s8 <= ctx_s7;
			side_s8 <= side_s7;
			r2_s8 <= r2sum8[61:30];
		end
	end

	// Stage 9: depth times (tangent squared plus one).
	ctx_t ctx_s9;
	side_t side_s9;
	logic [31:0] r2_s9;
	logic [62:0] prod_s9;
	logic v_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s9 <= ctx_s8;
			side_s9 <= side_s8;
			r2_s9 <= r2_s8;
			prod_s9 <= 63'(ctx_s8.depth) * 63'(r2_s8 + {1'b0, ONE_Q30});
		end
	end

	// Stage 10: radius, axis distance and flags per branch.
	logic [63:0] fsum10;
	logic [32:0] fn10;
	logic qsat10;
	logic [30:0] rad10;
	logic [30:0] dist10;
	logic err10;
	logic sat10;
	ctx_t ctx_s10;
	logic [30:0] rad_s10;
	logic [30:0] dist_s10;
	logic err_s10;
	logic sat_s10;
	logic v_s10;

	always_comb begin
		fsum10 = {1'b0, prod_s9} + 64'h4000_0000;
		fn10 = fsum10[63:31];
		qsat10 = side_s9.ovf || side_s9.q[31];
		rad10 = '0;
		dist10 = '0;
		err10 = 1'b0;
		sat10 = 1'b0;
		unique case (side_s9.br)
			BR_INSCRIBED: begin
				rad10 = r2_s9[30:0];
				dist10 = side_s9.q[30:0];
			end
			BR_APEX: begin
				rad10 = ctx_s9.depth;
			end
			BR_ERROR: begin
				err10 = 1'b1;
			end
			BR_SPH_WIDE: begin
				rad10 = side_s9.rad_sw;
				dist10 = side_s9.dist_sw;
			end
			BR_SPH_NARROW: begin
				rad10 = qsat10 ? RADIUS_MAX : side_s9.q[30:0];
				sat10 = qsat10;
				dist10 = rad10;
			end
			BR_FLAT_WIDE: begin
				rad10 = qsat10 ? RADIUS_MAX : side_s9.q[30:0];
				sat10 = qsat10;
				dist10 = ctx_s9.depth;
			end
			BR_FLAT_NARROW: begin
				sat10 = fn10 > {2'b0, RADIUS_MAX};
				rad10 = sat10 ? RADIUS_MAX : fn10[30:0];
				dist10 = rad10;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s10 <= ctx_s9;
			rad_s10 <= rad10;
			dist_s10 <= dist10;
			err_s10 <= err10;
			sat_s10 <= sat10;
		end
	end

	// Stage 11: axis offsets.
	ctx_t ctx_s11;
	logic [30:0] rad_s11;
	logic err_s11;
	logic sat_s11;
	logic signed [47:0] ox_s11;
	logic signed [47:0] oy_s11;
	logic signed [47:0] oz_s11;
	logic v_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s11 <= ctx_s10;
			rad_s11 <= rad_s10;
			err_s11 <= err_s10;
			sat_s11 <= sat_s10;
			ox_s11 <= $signed({1'b0, dist_s10}) * $signed(ctx_s10.axis_x);
			oy_s11 <= $signed({1'b0, dist_s10}) * $signed(ctx_s10.axis_y);
			oz_s11 <= $signed({1'b0, dist_s10}) * $signed(ctx_s10.axis_z);
		end
	end

	// Stage 12: round offsets from Q2.14.
	ctx_t ctx_s12;
	logic [30:0] rad_s12;
	logic err_s12;
	logic sat_s12;
	logic signed [33:0] rx_s12;
	logic signed [33:0] ry_s12;
	logic signed [33:0] rz_s12;
	logic v_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s12 <= ctx_s11;
			rad_s12 <= rad_s11;
			err_s12 <= err_s11;
			sat_s12 <= sat_s11;
			rx_s12 <= 34'((ox_s11 + 48'sd8192) >>> 14);
			ry_s12 <= 34'((oy_s11 + 48'sd8192) >>> 14);
			rz_s12 <= 34'((oz_s11 + 48'sd8192) >>> 14);
		end
	end

	// Stage 13: add the apex and saturate.
	logic [32:0] cx13;
	logic [32:0] cy13;
	logic [32:0] cz13;
	res_t res_s13;
	logic v_s13;

	always_comb begin
		cx13 = coord_sat(ctx_s12.apex_x, rx_s12);
		cy13 = coord_sat(ctx_s12.apex_y, ry_s12);
		cz13 = coord_sat(ctx_s12.apex_z, rz_s12);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s13.sphere_x <= $signed(cx13[31:0]);
			res_s13.sphere_y <= $signed(cy13[31:0]);
			res_s13.sphere_z <= $signed(cz13[31:0]);
			res_s13.sphere_radius <= rad_s12;
			res_s13.angle_error <= err_s12;
			res_s13.saturated <= sat_s12 | cx13[32] | cy13[32] | cz13[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s3 <= cv_s2[TRIG_STAGES-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s7 <= dv_s6[DIV_STEPS-1];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// Output register with one skid entry.
	assign push = en && v_s13;
	assign o_take = !o_v_q || sphere.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (o_take) begin
			if (skid_v_q) begin
				o_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				o_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_take) begin
			o_q <= skid_v_q ? skid_q : res_s13;
		end else if (push) begin
			skid_q <= res_s13;
		end
	end

	assign sphere.valid = o_v_q;
	assign sphere.sphere_x = o_q.sphere_x;
	assign sphere.sphere_y = o_q.sphere_y;
	assign sphere.sphere_z = o_q.sphere_z;
	assign sphere.sphere_radius = o_q.sphere_radius;
	assign sphere.angle_error = o_q.angle_error;
	assign sphere.saturated = o_q.saturated;

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(sphere.valid && !sphere.ready))
		else $error("skid entry filled while the output was free");

	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> sphere.valid)
		else $error("skid entry holds a beat while the output is empty");

	a_error_sphere: assert property (@(posedge clk) disable iff (!arst_n)
		(sphere.valid && sphere.angle_error) |->
		(sphere.sphere_radius == '0 && !sphere.saturated))
		else $error("angle error beat carries a radius or saturation");

endmodule
